// ===== src/qpdt_pkg.sv =====
// Shared types and codes for the QPACK dynamic table engine.
package qpdt_pkg;

    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_WRITE     = 3'd1;
    localparam logic [2:0] OP_LOOKUP    = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_CAPACITY  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    localparam int CAP_W = 18;
    localparam logic [CAP_W-1:0] CAP_RESET = '0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_LOOP,
        S_CAP_LOOP,
        S_EV_A,
        S_EV_B,
        S_WR,
        S_LK_A,
        S_LK_B,
        S_LK_RD,
        S_RD_RED,
        S_RD_MEM,
        S_FINISH
    } state_t;

endpackage

// ===== src/qpdt_ram.sv =====
// Simple dual-port RAM with registered read data.
module qpdt_ram
    import qpdt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = 6
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/qpdt_sub64.sv =====
// Shared 64-bit subtractor used for the absolute index compares.
module qpdt_sub64
    import qpdt_pkg::*;
(
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] diff,
    output logic        borrow
);

    logic [64:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[63:0];
    assign borrow = wide[64];

endmodule

// ===== src/qpack_dynamic_table.sv =====
// QPACK dynamic table engine: insert, fill, lookup, read and capacity eviction.
// One item is worked at a time under a small sequencer; the input is stalled from
// acceptance until the result is handed to the output register. A write byte is
// stored in the write state; a lookup makes two passes through the shared 64-bit
// subtractor, then one entry-table read, skipped when the index is closed; a read byte
// subtracts ARENA_BYTES from the offset while it is that large, then reads the arena;
// an insert ends at the size check if rejected, else evicts until it fits, and apply
// capacity evicts until the table fits (each eviction reads the entry table once and
// goes back through the fit check). The arena and entry table are RAMs, never cleared.
module qpack_dynamic_table
    import qpdt_pkg::*;
#(
    parameter int ENTRY_OVERHEAD = 32,
    parameter int MAX_ENTRIES    = 64,
    parameter int ARENA_BYTES    = 4096
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] name_len,
    input  logic [15:0] value_len,
    input  logic [7:0]  data_byte,
    input  logic [63:0] lookup_index,
    input  logic [11:0] read_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] assigned_index,
    output logic [11:0] entry_offset,
    output logic [15:0] found_name_length,
    output logic [15:0] found_value_length,
    output logic [7:0]  read_data
);

    localparam int AW = (ARENA_BYTES > 1) ? $clog2(ARENA_BYTES) : 1;
    localparam int LW = AW + 1;
    localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = AW + 32;
    localparam logic [17:0] ARENA18 = 18'(ARENA_BYTES);
    localparam logic [17:0] OVH18   = 18'(ENTRY_OVERHEAD);
    localparam logic [LW-1:0] ARENA_L = LW'(ARENA_BYTES);
    localparam logic [SW:0] MAX_S   = (SW+1)'(MAX_ENTRIES);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [CAP_W-1:0] cap_reg;
    logic [SW-1:0]    oldest_reg, oldest_next;
    logic [CW-1:0]    live_reg, live_next;
    logic [17:0]      tsize_reg, tsize_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [LW-1:0]    used_reg, used_next;
    logic [LW-1:0]    wp_reg, wp_next;
    logic [63:0]      ins_total_reg, ins_total_next;
    logic [63:0]      ev_total_reg, ev_total_next;

    logic [2:0]  op_reg;
    logic [15:0] nl_reg, vl_reg;
    logic [7:0]  byte_reg;
    logic [63:0] aidx_reg;
    logic [11:0] roff_reg, roff_next;
    logic        lk_lt_reg, lk_lt_next;
    logic [63:0] lk_rel_reg, lk_rel_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [63:0] res_index_reg, res_index_next;
    logic [11:0] res_off_reg, res_off_next;
    logic [15:0] res_nl_reg, res_nl_next;
    logic [15:0] res_vl_reg, res_vl_next;
    logic [7:0]  res_data_reg, res_data_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  o_status_reg;
    logic [63:0] o_index_reg;
    logic [11:0] o_off_reg;
    logic [15:0] o_nl_reg, o_vl_reg;
    logic [7:0]  o_data_reg;

    logic        accept;
    logic        out_load;

    // entry table and arena ports
    logic          ent_we;
    logic [SW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic          ar_we;
    logic [AW-1:0] ar_waddr, ar_raddr;
    logic [7:0]    ar_rdata;

    logic [AW-1:0] ev_start;
    logic [15:0]   ev_nl, ev_vl;

    logic [63:0] sub_b, sub_diff;
    logic        sub_borrow;

    // combinational helpers
    logic [17:0]   bytes18, esize18, ev_gone18, ev_esize18, base_sum18;
    logic [18:0]   fit_sum;
    logic          need_evict_ins, need_evict_cap, ins_reject, arena_short;
    logic [SW:0]   commit_sum, lk_sum;
    logic [SW-1:0] commit_slot, lk_slot;
    logic [LW-1:0] start_sum, wr_logical, wr_sum, rd_sum;
    logic [AW-1:0] commit_start, wr_phys, rd_phys;
    logic          rd_big, lk_miss;
    logic [AW-1:0] eoff_aw;
    logic [17:0]   roff18;
    logic          cfg_write;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? 32'(cap_reg) : 32'd0;

    qpdt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(EW), .AW(SW)) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    qpdt_ram #(.DEPTH(ARENA_BYTES), .WIDTH(8), .AW(AW)) u_arena (
        .clk   (clk),
        .we    (ar_we),
        .waddr (ar_waddr),
        .wdata (byte_reg),
        .raddr (ar_raddr),
        .rdata (ar_rdata)
    );

    assign sub_b = (state_reg == S_LK_A) ? ev_total_reg : ins_total_reg;

    qpdt_sub64 u_sub (
        .a      (aidx_reg),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign ev_start = ent_rdata[EW-1:32];
    assign ev_nl    = ent_rdata[31:16];
    assign ev_vl    = ent_rdata[15:0];

    always_comb
    begin
        bytes18    = 18'(nl_reg) + 18'(vl_reg);
        esize18    = bytes18 + OVH18;
        ins_reject = (esize18 > cap_reg) || (live_reg >= MAX_C) || (bytes18 > ARENA18);
        fit_sum    = 19'(tsize_reg) + 19'(esize18);
        need_evict_ins = (live_reg != '0) && (fit_sum > 19'(cap_reg));
        need_evict_cap = (live_reg != '0) && (tsize_reg > cap_reg);
        arena_short    = (18'(used_reg) + bytes18) > ARENA18;

        commit_sum  = {1'b0, oldest_reg} + (SW+1)'(live_reg);
        commit_slot = (commit_sum >= MAX_S) ? SW'(commit_sum - MAX_S) : SW'(commit_sum);
        start_sum   = LW'(base_reg) + used_reg;
        commit_start = (start_sum >= ARENA_L) ? AW'(start_sum - ARENA_L) : AW'(start_sum);

        ev_gone18  = 18'(ev_nl) + 18'(ev_vl);
        ev_esize18 = ev_gone18 + OVH18;
        base_sum18 = 18'(base_reg) + ev_gone18;

        wr_logical = used_reg - wp_reg;
        wr_sum     = LW'(base_reg) + wr_logical;
        wr_phys    = (wr_sum >= ARENA_L) ? AW'(wr_sum - ARENA_L) : AW'(wr_sum);

        roff18 = 18'(roff_reg);
        rd_big = (roff18 >= ARENA18);
        rd_sum = LW'(base_reg) + LW'(roff18);
        rd_phys = (rd_sum >= ARENA_L) ? AW'(rd_sum - ARENA_L) : AW'(rd_sum);

        lk_miss = (lk_rel_reg[63:CW] != '0) || (lk_rel_reg[CW-1:0] >= live_reg);
        lk_sum  = {1'b0, oldest_reg} + {1'b0, lk_rel_reg[SW-1:0]};
        lk_slot = (lk_sum >= MAX_S) ? SW'(lk_sum - MAX_S) : SW'(lk_sum);

        eoff_aw = (ev_start >= base_reg) ? AW'(ev_start - base_reg)
                                         : AW'(LW'(ev_start) + ARENA_L - LW'(base_reg));
    end

    assign ent_we    = (state_reg == S_INS_LOOP) && !need_evict_ins && !arena_short;
    assign ent_waddr = commit_slot;
    assign ent_wdata = {commit_start, nl_reg, vl_reg};
    assign ent_raddr = (state_reg == S_LK_B) ? lk_slot : oldest_reg;
    assign ar_we     = (state_reg == S_WR) && (wp_reg != '0);
    assign ar_waddr  = wr_phys;
    assign ar_raddr  = rd_phys;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_INSERT:   state_next = S_INS_CHK;
                        OP_WRITE:    state_next = S_WR;
                        OP_LOOKUP:   state_next = S_LK_A;
                        OP_READ:     state_next = S_RD_RED;
                        OP_CAPACITY: state_next = S_CAP_LOOP;
                        default:     state_next = S_FINISH;
                    endcase
                end
            end
            S_INS_CHK:  state_next = ins_reject ? S_FINISH : S_INS_LOOP;
            S_INS_LOOP: state_next = need_evict_ins ? S_EV_A : S_FINISH;
            S_CAP_LOOP: state_next = need_evict_cap ? S_EV_A : S_FINISH;
            S_EV_A:     state_next = S_EV_B;
            S_EV_B:     state_next = (op_reg == OP_INSERT) ? S_INS_LOOP : S_CAP_LOOP;
            S_WR:       state_next = S_FINISH;
            S_LK_A:     state_next = S_LK_B;
            S_LK_B:     state_next = (lk_lt_reg || !sub_borrow || lk_miss) ? S_FINISH : S_LK_RD;
            S_LK_RD:    state_next = S_FINISH;
            S_RD_RED:   state_next = rd_big ? S_RD_RED : S_RD_MEM;
            S_RD_MEM:   state_next = S_FINISH;
            S_FINISH:   state_next = out_load ? S_IDLE : S_FINISH;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        oldest_next    = oldest_reg;
        live_next      = live_reg;
        tsize_next     = tsize_reg;
        base_next      = base_reg;
        used_next      = used_reg;
        wp_next        = wp_reg;
        ins_total_next = ins_total_reg;
        ev_total_next  = ev_total_reg;
        roff_next      = roff_reg;
        lk_lt_next     = lk_lt_reg;
        lk_rel_next    = lk_rel_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_off_next    = res_off_reg;
        res_nl_next     = res_nl_reg;
        res_vl_next     = res_vl_reg;
        res_data_next   = res_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    roff_next       = read_offset;
                    res_status_next = (operation > OP_CAPACITY) ? ST_LIMIT : ST_OK;
                    res_index_next  = '0;
                    res_off_next    = '0;
                    res_nl_next     = '0;
                    res_vl_next     = '0;
                    res_data_next   = '0;
                end
            end
            S_INS_CHK:
            begin
                if (ins_reject)
                begin
                    res_status_next = ST_LIMIT;
                end
            end
            S_INS_LOOP:
            begin
                if (!need_evict_ins)
                begin
                    if (arena_short)
                    begin
                        res_status_next = ST_LIMIT;
                    end
                    else
                    begin
                        live_next      = live_reg + CW'(1);
                        used_next      = used_reg + LW'(bytes18);
                        tsize_next     = tsize_reg + esize18;
                        wp_next        = LW'(bytes18);
                        res_index_next = ins_total_reg;
                        ins_total_next = ins_total_reg + 64'd1;
                    end
                end
            end
            S_EV_A:
            begin
                tsize_next = (tsize_reg >= ev_esize18) ? tsize_reg - ev_esize18 : 18'd0;
                base_next  = (base_sum18 >= ARENA18) ? AW'(base_sum18 - ARENA18)
                                                     : AW'(base_sum18);
                used_next  = (18'(used_reg) >= ev_gone18) ? LW'(18'(used_reg) - ev_gone18)
                                                          : '0;
            end
            S_EV_B:
            begin
                oldest_next   = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + SW'(1);
                live_next     = live_reg - CW'(1);
                ev_total_next = ev_total_reg + 64'd1;
                // cut pending fill bytes to what is still reserved
                if (wp_reg > used_reg)
                begin
                    wp_next = used_reg;
                end
            end
            S_WR:
            begin
                if (wp_reg == '0)
                begin
                    res_status_next = ST_LIMIT;
                end
                else
                begin
                    wp_next = wp_reg - LW'(1);
                end
            end
            S_LK_A:
            begin
                lk_lt_next  = sub_borrow;
                lk_rel_next = sub_diff;
            end
            S_LK_B:
            begin
                if (lk_lt_reg || !sub_borrow || lk_miss)
                begin
                    res_status_next = ST_CLOSED;
                end
            end
            S_LK_RD:
            begin
                res_off_next = 12'(eoff_aw);
                res_nl_next  = ev_nl;
                res_vl_next  = ev_vl;
            end
            S_RD_RED:
            begin
                if (rd_big)
                begin
                    roff_next = roff_reg - 12'(ARENA_BYTES);
                end
            end
            S_RD_MEM:
            begin
                res_data_next = ar_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            oldest_reg    <= '0;
            live_reg      <= '0;
            tsize_reg     <= '0;
            base_reg      <= '0;
            used_reg      <= '0;
            wp_reg        <= '0;
            ins_total_reg <= '0;
            ev_total_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            oldest_reg    <= oldest_next;
            live_reg      <= live_next;
            tsize_reg     <= tsize_next;
            base_reg      <= base_next;
            used_reg      <= used_next;
            wp_reg        <= wp_next;
            ins_total_reg <= ins_total_next;
            ev_total_reg  <= ev_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            nl_reg   <= name_len;
            vl_reg   <= value_len;
            byte_reg <= data_byte;
            aidx_reg <= lookup_index;
        end
        roff_reg        <= roff_next;
        lk_lt_reg       <= lk_lt_next;
        lk_rel_reg      <= lk_rel_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        res_off_reg     <= res_off_next;
        res_nl_reg      <= res_nl_next;
        res_vl_reg      <= res_vl_next;
        res_data_reg    <= res_data_next;
        if (out_load)
        begin
            o_status_reg <= res_status_reg;
            o_index_reg  <= res_index_reg;
            o_off_reg    <= res_off_reg;
            o_nl_reg     <= res_nl_reg;
            o_vl_reg     <= res_vl_reg;
            o_data_reg   <= res_data_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = o_status_reg;
    assign assigned_index     = o_index_reg;
    assign entry_offset       = o_off_reg;
    assign found_name_length  = o_nl_reg;
    assign found_value_length = o_vl_reg;
    assign read_data          = o_data_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= MAX_C)
        else $error("live entry count above table depth");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= ARENA_L)
        else $error("arena use above arena size");

    // the pending count is cut in S_EV_B, after an eviction shrinks the reserved bytes in S_EV_A
    a_wp_in_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_B) || (wp_reg <= used_reg))
        else $error("pending fill bytes exceed reserved bytes");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after an accepted beat");

endmodule
